/* design/dual_frame_byte_deframer_defines.svh */
// Assertion macros used by the deframer top level
`ifndef DUAL_FRAME_BYTE_DEFRAMER_DEFINES_SVH
`define DUAL_FRAME_BYTE_DEFRAMER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define DFD_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define DFD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/dfd_pkg.sv */
// Types and constants shared by the deframer modules
package dfd_pkg;

  localparam int CNT_W   = 5;
  localparam int TDATA_W = 96;

  // last byte count of an 11-byte service frame
  localparam logic [CNT_W-1:0] SVC_LAST_CNT = 5'd10;

  localparam logic [7:0] CMD_HEADER_RST = 8'hAA;
  localparam logic [7:0] SVC_MAGIC_RST  = 8'hA5;
  localparam logic [7:0] CMD_TYPE_RST   = 8'h01;

  typedef enum logic [1:0] {
    CFG_CMD_HEADER = 2'd0,
    CFG_SVC_MAGIC  = 2'd1,
    CFG_CMD_TYPE   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_CMD  = 2'd1,
    MODE_SVC  = 2'd2
  } mode_e;

  typedef enum logic {
    KIND_CMD = 1'b0,
    KIND_SVC = 1'b1
  } kind_e;

  // completed frame handed from front to back
  typedef struct packed {
    kind_e       kind;
    logic        bank;
    logic [15:0] svc_id;
    logic [63:0] payload;
  } job_t;

  // frame store write request
  typedef struct packed {
    logic             we;
    logic             bank;
    logic [CNT_W-1:0] idx;
    logic [7:0]       data;
  } wr_req_t;

  // bank handed back once its last byte has been read
  typedef struct packed {
    logic vld;
    logic bank;
  } rel_t;

endpackage

/* design/dfd_front.sv */
// Byte parser: configuration, frame tracking and frame store writes
module dfd_front import dfd_pkg::*; #(
  parameter int CMD_FRAME_LEN = 24
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       s_valid_i,
  input  logic [7:0] s_data_i,
  output logic       s_ready_o,
  input  logic       q_full_i,
  input  rel_t       rel_i,
  output logic       push_o,
  output job_t       job_o,
  output wr_req_t    wr_o
);

  localparam logic [CNT_W-1:0] CmdLast = CNT_W'(CMD_FRAME_LEN - 1);

  logic [7:0] cmd_header_q, svc_magic_q, cmd_type_q;
  mode_e      mode_q, mode_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic       wr_bank_q;
  logic [1:0] busy_q, busy_d;
  logic [79:0] sh_q, sh_d;

  logic       acc, hit_cmd, hit_svc, type_bad;
  mode_e      start_mode;
  logic [CNT_W-1:0] start_cnt;

  assign s_ready_o = !q_full_i && !busy_q[wr_bank_q];
  assign acc       = s_valid_i && s_ready_o;
  assign hit_cmd   = (s_data_i == cmd_header_q);
  assign hit_svc   = !hit_cmd && (s_data_i == svc_magic_q);
  assign type_bad  = (cnt_q == CNT_W'(1)) && (s_data_i != cmd_type_q);
  assign start_mode = hit_cmd ? MODE_CMD : (hit_svc ? MODE_SVC : MODE_IDLE);
  assign start_cnt  = (hit_cmd || hit_svc) ? CNT_W'(1) : '0;

  // next state
  always_comb begin
    mode_d = mode_q;
    cnt_d  = cnt_q;
    if (acc) begin
      case (mode_q)
        MODE_CMD: begin
          if (type_bad) begin
            mode_d = start_mode;
            cnt_d  = start_cnt;
          end else if (cnt_q == CmdLast) begin
            mode_d = MODE_IDLE;
            cnt_d  = '0;
          end else begin
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
        MODE_SVC: begin
          if (cnt_q == SVC_LAST_CNT) begin
            mode_d = MODE_IDLE;
            cnt_d  = '0;
          end else begin
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
        default: begin
          mode_d = start_mode;
          cnt_d  = start_cnt;
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    sh_d          = {sh_q[71:0], s_data_i};
    wr_o.we       = 1'b0;
    wr_o.bank     = wr_bank_q;
    wr_o.idx      = '0;
    wr_o.data     = s_data_i;
    push_o        = 1'b0;
    job_o.kind    = KIND_CMD;
    job_o.bank    = wr_bank_q;
    job_o.svc_id  = sh_d[79:64];
    job_o.payload = sh_d[63:0];
    if (acc) begin
      case (mode_q)
        MODE_CMD: begin
          if (type_bad) begin
            wr_o.we = hit_cmd;
          end else begin
            wr_o.we  = 1'b1;
            wr_o.idx = cnt_q;
            push_o   = (cnt_q == CmdLast);
          end
        end
        MODE_SVC: begin
          job_o.kind = KIND_SVC;
          push_o     = (cnt_q == SVC_LAST_CNT);
        end
        default: begin
          wr_o.we = hit_cmd;
        end
      endcase
    end
  end

  // hand a finished command bank to the back end; free a bank once read out
  always_comb begin
    busy_d = busy_q;
    if (push_o && job_o.kind == KIND_CMD) begin
      busy_d[wr_bank_q] = 1'b1;
    end
    if (rel_i.vld) begin
      busy_d[rel_i.bank] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_header_q <= CMD_HEADER_RST;
      svc_magic_q  <= SVC_MAGIC_RST;
      cmd_type_q   <= CMD_TYPE_RST;
      mode_q       <= MODE_IDLE;
      cnt_q        <= '0;
      wr_bank_q    <= 1'b0;
      busy_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CMD_HEADER: cmd_header_q <= cfg_wdata_i;
          CFG_SVC_MAGIC:  svc_magic_q  <= cfg_wdata_i;
          CFG_CMD_TYPE:   cmd_type_q   <= cfg_wdata_i;
          default: ;
        endcase
      end
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      // switch banks once a command frame is complete
      if (push_o && job_o.kind == KIND_CMD) begin
        wr_bank_q <= !wr_bank_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && mode_q == MODE_SVC) begin
      sh_q <= sh_d;
    end
  end

endmodule

/* design/dfd_fifo.sv */
// Two-entry queue of completed frames between parser and emitter
module dfd_fifo import dfd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output job_t job_o,
  output logic full_o,
  output logic empty_o
);

  job_t       ent_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign job_o   = ent_q[rd_ptr_q];
  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wr_ptr_q] <= job_i;
  end

endmodule

/* design/dfd_back.sv */
// Emitter: frame store, read stage and output register
module dfd_back import dfd_pkg::*; #(
  parameter int CMD_FRAME_LEN = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wr_req_t            wr_i,
  input  job_t               job_i,
  input  logic               q_empty_i,
  output logic               pop_o,
  output rel_t               rel_o,
  output logic               m_valid_o,
  input  logic               m_ready_i,
  output logic [TDATA_W-1:0] m_data_o,
  output logic               m_user_o,
  output logic               m_last_o
);

  localparam int IdxW = (CMD_FRAME_LEN > 1) ? $clog2(CMD_FRAME_LEN) : 1;
  localparam logic [CNT_W-1:0] CmdLast = CNT_W'(CMD_FRAME_LEN - 1);

  logic [7:0] mem_q [2][CMD_FRAME_LEN];
  logic [7:0] rd_data_q;

  logic             rd_busy_q, bank_q;
  logic [CNT_W-1:0] idx_q;

  logic             s1_vld_q;
  kind_e            s1_kind_q;
  logic [CNT_W-1:0] s1_idx_q;
  logic             s1_last_q;
  logic [15:0]      s1_id_q;
  logic [63:0]      s1_pay_q;

  logic             out_vld_q;
  kind_e            out_kind_q;
  logic [7:0]       out_data_q;
  logic [CNT_W-1:0] out_idx_q;
  logic [15:0]      out_id_q;
  logic [63:0]      out_pay_q;
  logic             out_last_q;

  logic adv, issue, rd_last;

  assign adv     = !out_vld_q || m_ready_i;
  assign issue   = adv && rd_busy_q;
  assign rd_last = (idx_q == CmdLast);
  assign pop_o   = adv && !rd_busy_q && !q_empty_i;

  assign rel_o.vld  = issue && rd_last;
  assign rel_o.bank = bank_q;

  assign m_valid_o = out_vld_q;
  assign m_user_o  = out_kind_q;
  assign m_last_o  = out_last_q;
  assign m_data_o  = {3'b000, out_pay_q, out_id_q, out_idx_q, out_data_q};

  always_ff @(posedge clk_i) begin
    if (wr_i.we) mem_q[wr_i.bank][wr_i.idx[IdxW-1:0]] <= wr_i.data;
    if (issue)   rd_data_q <= mem_q[bank_q][idx_q[IdxW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_busy_q <= 1'b0;
      bank_q    <= 1'b0;
      idx_q     <= '0;
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (issue) begin
        idx_q <= idx_q + CNT_W'(1);
        if (rd_last) rd_busy_q <= 1'b0;
      end else if (pop_o && job_i.kind == KIND_CMD) begin
        rd_busy_q <= 1'b1;
        bank_q    <= job_i.bank;
        idx_q     <= '0;
      end
      if (adv) begin
        s1_vld_q  <= issue || (pop_o && job_i.kind == KIND_SVC);
        out_vld_q <= s1_vld_q;
      end
    end
  end

  // stage payloads advance together with their valid flags
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_kind_q  <= issue ? KIND_CMD : KIND_SVC;
      s1_idx_q   <= idx_q;
      s1_last_q  <= issue ? rd_last : 1'b1;
      s1_id_q    <= job_i.svc_id;
      s1_pay_q   <= job_i.payload;
      out_kind_q <= s1_kind_q;
      out_last_q <= s1_last_q;
      out_data_q <= (s1_kind_q == KIND_CMD) ? rd_data_q : 8'd0;
      out_idx_q  <= (s1_kind_q == KIND_CMD) ? s1_idx_q : '0;
      out_id_q   <= (s1_kind_q == KIND_SVC) ? s1_id_q : 16'd0;
      out_pay_q  <= (s1_kind_q == KIND_SVC) ? s1_pay_q : 64'd0;
    end
  end

endmodule

/* design/dual_frame_byte_deframer.sv */
// Path: each result passes the frame queue, read stage and output register; a command frame
// gives one result per cycle for the whole frame while the output register is not stalled.
// Input: one byte per cycle; any byte waits while the two-entry frame queue is full or the
// current store bank is still queued for or in read-out (two banks of CMD_FRAME_LEN bytes).
// Reset: asynchronous, active low; clears control state and loads register defaults.
// The frame store needs no clearing pass: every byte read was written in its frame.
`include "dual_frame_byte_deframer_defines.svh"

module dual_frame_byte_deframer import dfd_pkg::*; #(
  parameter int CMD_FRAME_LEN = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // rx_byte
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // data_byte, byte_index, service_id, service_payload, zero fill
  output logic [TDATA_W-1:0] m_axis_tdata,
  output logic               m_axis_tuser,   // frame_kind
  output logic               m_axis_tlast
);

  logic    push, pop, q_full, q_empty;
  job_t    job_in, job_out;
  wr_req_t wr_req;
  rel_t    rel;

  dfd_front #(
    .CMD_FRAME_LEN(CMD_FRAME_LEN)
  ) u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .s_valid_i (s_axis_tvalid),
    .s_data_i  (s_axis_tdata),
    .s_ready_o (s_axis_tready),
    .q_full_i  (q_full),
    .rel_i     (rel),
    .push_o    (push),
    .job_o     (job_in),
    .wr_o      (wr_req)
  );

  dfd_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .job_o   (job_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  dfd_back #(
    .CMD_FRAME_LEN(CMD_FRAME_LEN)
  ) u_back (
    .clk_i,
    .rst_ni,
    .wr_i      (wr_req),
    .job_i     (job_out),
    .q_empty_i (q_empty),
    .pop_o     (pop),
    .rel_o     (rel),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_user_o  (m_axis_tuser),
    .m_last_o  (m_axis_tlast)
  );

  `DFD_ASSERT_IMPL(a_no_overflow, q_full, !push, "frame queue pushed while full")
  `DFD_ASSERT_IMPL(a_svc_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast,
                   "service result without last")
  `DFD_ASSERT_IMPL(a_cmd_last, m_axis_tvalid && !m_axis_tuser && m_axis_tlast,
                   m_axis_tdata[12:8] == CNT_W'(CMD_FRAME_LEN - 1),
                   "command last on wrong byte index")
  `DFD_ASSERT_NEXT(a_pop_empty, q_empty && !push, !pop || !q_empty,
                   "queue popped while empty")

endmodule
